FILE: hdl/assert_macros.svh
// Assertion helpers included by the top-level decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define MFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hdl/mfd_pkg.sv
package mfd_pkg;

    // Encoder counts per rotor revolution.
    localparam int ENC_COUNTS = 8192;

    // Field widths.
    localparam int POS_W  = 16;
    localparam int SPD_W  = 16;
    localparam int CUR_W  = 16;
    localparam int TEMP_W = 8;
    localparam int GEAR_W = 8;
    localparam int TOT_W  = 24;
    localparam int ANG_W  = 19;

    // Q16 angle constants: round(2*pi*65536) and round(pi*65536).
    localparam int ANG_TWO_PI = 411775;
    localparam int ANG_PI     = 205887;

    // Span = ENC_COUNTS * ratio, ratio up to 255.
    localparam int SPAN_W = $clog2(ENC_COUNTS * 255 + 1);

    // Wrapped delta and folded sum widths. The delta spans the full
    // difference of two signed encoder words plus one turn.
    localparam int D_W   = ((POS_W > $clog2(ENC_COUNTS + 1)) ? POS_W
                                                             : $clog2(ENC_COUNTS + 1)) + 2;
    localparam int SUM_W = ((TOT_W > SPAN_W + 1) ? TOT_W : SPAN_W + 1) + 2;

    // |total| <= 2^(TOT_W-1) and ANG_TWO_PI < 2^ANG_W, so the product fits here.
    localparam int DIV_W = TOT_W + ANG_W - 1;
    localparam int CNT_W = $clog2(DIV_W + 1);

    localparam logic [CNT_W-1:0] SPD_STEPS = CNT_W'(SPD_W);
    localparam logic [CNT_W-1:0] ANG_STEPS = CNT_W'(DIV_W);

    // Configuration register map.
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_GEAR_RATIO = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNWRAP,
        ST_MUL,
        ST_SPD_WAIT,
        ST_ANG_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: hdl/mfd_div.sv
module mfd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mfd_pkg::t_div_req           i_req,
    input  logic [mfd_pkg::DIV_W-1:0]   i_dividend,
    input  logic [mfd_pkg::SPAN_W-1:0]  i_divisor,
    output mfd_pkg::t_div_stat          o_stat,
    output logic [mfd_pkg::DIV_W-1:0]   o_quotient
);
    import mfd_pkg::*;

    // Restoring divider, one quotient bit per cycle. The dividend is
    // left aligned; after n steps the low n bits hold the quotient.
    logic [SPAN_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [SPAN_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [SPAN_W:0]   w_trial;
    logic [SPAN_W:0]   w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign n_rem   = w_ge ? w_diff[SPAN_W-1:0] : w_trial[SPAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

FILE: hdl/mfd_unwrap.sv
module mfd_unwrap (
    input  logic signed [mfd_pkg::POS_W-1:0]  i_cur,
    input  logic signed [mfd_pkg::POS_W-1:0]  i_prev,
    input  logic signed [mfd_pkg::TOT_W-1:0]  i_total,
    input  logic        [mfd_pkg::SPAN_W-1:0] i_span,
    output logic signed [mfd_pkg::TOT_W-1:0]  o_total
);
    import mfd_pkg::*;

    localparam logic signed [D_W-1:0] ENC_D = D_W'(ENC_COUNTS);

    logic signed [D_W-1:0]   w_diff;
    logic signed [D_W-1:0]   w_d1;
    logic signed [D_W-1:0]   w_d2;
    logic        [D_W-1:0]   w_mag1;
    logic        [D_W-1:0]   w_mag2;
    logic signed [D_W-1:0]   w_delta;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_span;
    logic signed [SUM_W-1:0] w_fold;

    assign w_diff = D_W'(i_cur) - D_W'(i_prev);

    // Two candidates, one wrapped across the encoder rollover.
    always_comb begin
        if (i_cur < i_prev) begin
            w_d1 = w_diff + ENC_D;
            w_d2 = w_diff;
        end else begin
            w_d1 = w_diff;
            w_d2 = w_diff - ENC_D;
        end
    end

    assign w_mag1  = w_d1[D_W-1] ? D_W'(-w_d1) : w_d1;
    assign w_mag2  = w_d2[D_W-1] ? D_W'(-w_d2) : w_d2;
    assign w_delta = (w_mag1 < w_mag2) ? w_d1 : w_d2;

    assign w_sum  = SUM_W'(i_total) + SUM_W'(w_delta);
    assign w_span = signed'({{(SUM_W - SPAN_W){1'b0}}, i_span});

    // Fold once into the span.
    always_comb begin
        if (w_sum < 0) begin
            w_fold = w_sum + w_span;
        end else if (w_sum > w_span) begin
            w_fold = w_sum - w_span;
        end else begin
            w_fold = w_sum;
        end
    end

    assign o_total = w_fold[TOT_W-1:0];

endmodule

FILE: hdl/motor_feedback_multiturn_decoder.sv
// Motor feedback decoder with multi-turn encoder unwrap.
//
// Input channel: one feedback frame per transfer (position, speed, current,
// temperature), taken when i_in_valid is high and o_in_stall is low.
// Output channel: one decoded result per frame, presented on o_out_valid and
// held while i_out_stall is high. The output register parts both sides, so a
// new frame is taken while the previous result still waits.
// Configuration: APB write of gear_ratio at byte address 0; pready is always
// high. Write it only while the block is idle. A ratio of 0 acts as 1.
// One frame at a time: the input stays stalled from the transfer through the
// unwrap, multiply, speed-divide and angle-divide states until the result
// is loaded into the output register. The pace is set by the one serial
// restoring divider, one quotient bit per cycle, used first for the shaft
// speed (16 steps) and then for the shaft angle (42 steps).
// A stalled output holds the sequencer in its last state until the result
// register frees up, and the input stays stalled meanwhile.
// Reset: synchronous, active low; clears the position history, the running
// total and the output valid, and sets gear_ratio to 1.
`include "assert_macros.svh"

module motor_feedback_multiturn_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [mfd_pkg::POS_W-1:0]    i_position_word,
    input  logic signed [mfd_pkg::SPD_W-1:0]    i_speed_word,
    input  logic signed [mfd_pkg::CUR_W-1:0]    i_current_word,
    input  logic        [mfd_pkg::TEMP_W-1:0]   i_temp_byte,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [mfd_pkg::POS_W-1:0]    o_rotor_pos,
    output logic signed [mfd_pkg::SPD_W-1:0]    o_rotor_speed,
    output logic signed [mfd_pkg::CUR_W-1:0]    o_torque_cur,
    output logic        [mfd_pkg::TEMP_W-1:0]   o_temperature,
    output logic signed [mfd_pkg::SPD_W-1:0]    o_shaft_speed,
    output logic signed [mfd_pkg::TOT_W-1:0]    o_accum_count,
    output logic signed [mfd_pkg::ANG_W-1:0]    o_shaft_angle,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import mfd_pkg::*;

    localparam logic [SPAN_W-1:0] ENC_VEC    = SPAN_W'(ENC_COUNTS);
    localparam logic [DIV_W-1:0]  TWO_PI_VEC = DIV_W'(ANG_TWO_PI);
    localparam logic [ANG_W-1:0]  PI_VEC     = ANG_W'(ANG_PI);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [GEAR_W-1:0]    r_gear;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_cfg_wr;

    assign w_reg_idx = paddr[2];
    assign w_cfg_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear <= GEAR_W'(1);
        end else if (w_cfg_wr && (w_reg_idx == REG_GEAR_RATIO)) begin
            r_gear <= pwdata[GEAR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_idx == REG_GEAR_RATIO) begin
            prdata[GEAR_W-1:0] = r_gear;
        end
    end

    // Zero ratio behaves as one.
    logic [GEAR_W-1:0] w_ratio;
    assign w_ratio = (r_gear == '0) ? GEAR_W'(1) : r_gear;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    t_state r_state, n_state;

    t_div_req              w_div_req;
    t_div_stat             w_div_stat;
    logic [DIV_W-1:0]      w_dividend;
    logic [DIV_W-1:0]      w_quotient;
    logic [DIV_W-1:0]      r_prod;
    logic                  r_out_valid;

    logic w_in_acc;
    logic w_out_free;
    logic w_load_total;
    logic w_load_prod;
    logic w_load_shaft;
    logic w_load_out;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (w_in_acc) n_state = ST_UNWRAP;
            ST_UNWRAP:   n_state = ST_MUL;
            ST_MUL:      n_state = ST_SPD_WAIT;
            ST_SPD_WAIT: if (w_div_stat.done) n_state = ST_ANG_WAIT;
            ST_ANG_WAIT: if (w_div_stat.done) n_state = ST_OUT;
            ST_OUT:      if (w_out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Frame registers, captured on the input transfer.
    logic signed [POS_W-1:0]  r_cur_pos;
    logic signed [POS_W-1:0]  r_prev_pos;
    logic signed [SPD_W-1:0]  r_spd;
    logic signed [CUR_W-1:0]  r_curr;
    logic        [TEMP_W-1:0] r_temp;
    logic        [SPAN_W-1:0] r_span;
    logic        [SPD_W-1:0]  w_spd_mag;

    assign w_spd_mag = r_spd[SPD_W-1] ? SPD_W'(-r_spd) : r_spd;

    always_comb begin
        w_div_req.start = 1'b0;
        w_div_req.steps = SPD_STEPS;
        w_dividend      = {w_spd_mag, {(DIV_W - SPD_W){1'b0}}};
        w_load_total    = 1'b0;
        w_load_prod     = 1'b0;
        w_load_shaft    = 1'b0;
        w_load_out      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_UNWRAP: begin
                // Kick off speed / ratio while the total is folded.
                w_div_req.start = 1'b1;
                w_load_total    = 1'b1;
            end
            ST_MUL: begin
                w_load_prod = 1'b1;
            end
            ST_SPD_WAIT: begin
                // Hand the divider straight over to the angle.
                w_div_req.steps = ANG_STEPS;
                w_dividend      = r_prod;
                w_div_req.start = w_div_stat.done;
                w_load_shaft    = w_div_stat.done;
            end
            ST_ANG_WAIT: begin
            end
            ST_OUT: begin
                w_load_out = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // Position history: drop the update of prev when cur is still zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_pos  <= '0;
            r_prev_pos <= '0;
        end else if (w_in_acc) begin
            if (r_cur_pos != '0) begin
                r_prev_pos <= r_cur_pos;
            end
            r_cur_pos <= i_position_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_spd  <= i_speed_word;
            r_curr <= i_current_word;
            r_temp <= i_temp_byte;
            r_span <= ENC_VEC * {{(SPAN_W - GEAR_W){1'b0}}, w_ratio};
        end
    end

    // ---------------------------------------------------------------
    // Unwrap and fold
    // ---------------------------------------------------------------
    logic signed [TOT_W-1:0] r_total;
    logic signed [TOT_W-1:0] w_new_total;

    mfd_unwrap u_unwrap (
        .i_cur   (r_cur_pos),
        .i_prev  (r_prev_pos),
        .i_total (r_total),
        .i_span  (r_span),
        .o_total (w_new_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (w_load_total) begin
            r_total <= w_new_total;
        end
    end

    // ---------------------------------------------------------------
    // Angle product: |total| * 2*pi in Q16, sign kept aside
    // ---------------------------------------------------------------
    logic             r_ang_neg;
    logic [TOT_W-1:0] w_tot_mag;

    assign w_tot_mag = r_total[TOT_W-1] ? TOT_W'(-r_total) : r_total;

    always_ff @(posedge i_clk) begin
        if (w_load_prod) begin
            r_prod    <= DIV_W'(w_tot_mag) * TWO_PI_VEC;
            r_ang_neg <= r_total[TOT_W-1];
        end
    end

    // ---------------------------------------------------------------
    // Shared serial divider
    // ---------------------------------------------------------------
    logic [SPAN_W-1:0] w_divisor;

    assign w_divisor = (r_state == ST_UNWRAP)
                     ? {{(SPAN_W - GEAR_W){1'b0}}, w_ratio}
                     : r_span;

    mfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    // Truncate toward zero: divide magnitudes, then restore the sign.
    logic signed [SPD_W-1:0] r_shaft;
    logic        [SPD_W-1:0] w_spd_q;
    logic        [ANG_W-1:0] w_ang_q;
    logic        [ANG_W-1:0] w_ang_signed;
    logic        [ANG_W-1:0] w_angle;

    assign w_spd_q      = w_quotient[SPD_W-1:0];
    assign w_ang_q      = w_quotient[ANG_W-1:0];
    assign w_ang_signed = r_ang_neg ? ANG_W'(-w_ang_q) : w_ang_q;
    assign w_angle      = w_ang_signed - PI_VEC;

    always_ff @(posedge i_clk) begin
        if (w_load_shaft) begin
            r_shaft <= r_spd[SPD_W-1] ? SPD_W'(-w_spd_q) : w_spd_q;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic signed [POS_W-1:0]  r_o_pos;
    logic signed [SPD_W-1:0]  r_o_spd;
    logic signed [CUR_W-1:0]  r_o_cur;
    logic        [TEMP_W-1:0] r_o_temp;
    logic signed [SPD_W-1:0]  r_o_shaft;
    logic signed [TOT_W-1:0]  r_o_total;
    logic signed [ANG_W-1:0]  r_o_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_pos   <= r_cur_pos;
            r_o_spd   <= r_spd;
            r_o_cur   <= r_curr;
            r_o_temp  <= r_temp;
            r_o_shaft <= r_shaft;
            r_o_total <= r_total;
            r_o_angle <= signed'(w_angle);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_rotor_pos   = r_o_pos;
    assign o_rotor_speed = r_o_spd;
    assign o_torque_cur  = r_o_cur;
    assign o_temperature = r_o_temp;
    assign o_shaft_speed = r_o_shaft;
    assign o_accum_count = r_o_total;
    assign o_shaft_angle = r_o_angle;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `MFD_ASSERT_SAME(a_div_start_idle, i_clk, i_rst_n, w_div_req.start, !w_div_stat.busy)
    `MFD_ASSERT_NEXT(a_unwrap_starts_div, i_clk, i_rst_n, r_state == ST_UNWRAP, w_div_stat.busy)
    `MFD_ASSERT_SAME(a_done_in_wait, i_clk, i_rst_n, w_div_stat.done, (r_state == ST_SPD_WAIT) || (r_state == ST_ANG_WAIT))

endmodule

FILE: dv/tb_motor_feedback_multiturn_decoder.sv
`timescale 1ns / 100ps

import mfd_pkg::*;

// One decoded feedback frame as it leaves the block.
typedef struct {
    logic signed [POS_W-1:0]  rotor_pos;
    logic signed [SPD_W-1:0]  rotor_speed;
    logic signed [CUR_W-1:0]  torque_cur;
    logic        [TEMP_W-1:0] temperature;
    logic signed [SPD_W-1:0]  shaft_speed;
    logic signed [TOT_W-1:0]  accum_count;
    logic signed [ANG_W-1:0]  shaft_angle;
} t_decoded_frame;

// Tracks the multi-turn unwrap state and queues the decoded frame that
// each accepted input frame should produce.
class feedback_scoreboard;
    logic        [GEAR_W-1:0] gear_ratio;
    logic signed [POS_W-1:0]  cur_pos;
    logic signed [POS_W-1:0]  prev_pos;
    logic signed [TOT_W-1:0]  turn_total;
    t_decoded_frame           decoded_q[$];
    int                       errors;

    function new();
        gear_ratio = 1;
        cur_pos    = '0;
        prev_pos   = '0;
        turn_total = '0;
        errors     = 0;
    endfunction

    function void set_gear(logic [GEAR_W-1:0] value);
        gear_ratio = value;
    endfunction

    function int pending();
        return decoded_q.size();
    endfunction

    // Unwrap one frame and queue its decoded result.
    function void note_frame(logic signed [POS_W-1:0] pos, logic signed [SPD_W-1:0] spd,
                             logic signed [CUR_W-1:0] cur, logic [TEMP_W-1:0] temp);
        t_decoded_frame r;
        longint         ratio;
        longint         span;
        longint         d1;
        longint         d2;
        longint         sum;
        longint         angle;
        ratio = (gear_ratio == 0) ? 1 : longint'(gear_ratio);
        span  = ENC_COUNTS * ratio;
        // a zero position never becomes the previous one
        if (cur_pos != 0)
            prev_pos = cur_pos;
        cur_pos = pos;
        if (cur_pos < prev_pos) begin
            d1 = longint'(cur_pos) + ENC_COUNTS - longint'(prev_pos);
            d2 = longint'(cur_pos) - longint'(prev_pos);
        end else begin
            d1 = longint'(cur_pos) - longint'(prev_pos);
            d2 = longint'(cur_pos) - ENC_COUNTS - longint'(prev_pos);
        end
        sum = longint'(turn_total) +
              (((d1 < 0 ? -d1 : d1) < (d2 < 0 ? -d2 : d2)) ? d1 : d2);
        if (sum < 0)
            sum = sum + span;
        else if (sum > span)
            sum = sum - span;
        turn_total = TOT_W'(sum);
        angle = longint'(turn_total) * ANG_TWO_PI / span - ANG_PI;

        r.rotor_pos   = pos;
        r.rotor_speed = spd;
        r.torque_cur  = cur;
        r.temperature = temp;
        r.shaft_speed = SPD_W'(longint'(spd) / ratio);
        r.accum_count = turn_total;
        r.shaft_angle = ANG_W'(angle);
        decoded_q.push_back(r);
    endfunction

    function void compare_field(string field, logic signed [31:0] want,
                                logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_decoded_frame got);
        t_decoded_frame want;
        if (decoded_q.size() == 0) begin
            $display("%0t: unexpected result, accum_count %0d", $time, got.accum_count);
            errors++;
            return;
        end
        want = decoded_q.pop_front();
        compare_field("rotor_pos",   want.rotor_pos,   got.rotor_pos);
        compare_field("rotor_speed", want.rotor_speed, got.rotor_speed);
        compare_field("torque_cur",  want.torque_cur,  got.torque_cur);
        compare_field("temperature", want.temperature, got.temperature);
        compare_field("shaft_speed", want.shaft_speed, got.shaft_speed);
        compare_field("accum_count", want.accum_count, got.accum_count);
        compare_field("shaft_angle", want.shaft_angle, got.shaft_angle);
    endfunction
endclass

module tb_motor_feedback_multiturn_decoder;

    // Spacing of input transfers on the serial divider path when the output is free, in cycles.
    localparam int LATENCY = DIV_W + SPD_W + 5;

    // Register addresses: the gear ratio and one index that decodes to nothing.
    localparam logic [2:0] GEAR_ADDR   = {REG_GEAR_RATIO, 2'b00};
    localparam logic [2:0] UNUSED_ADDR = {~REG_GEAR_RATIO, 2'b00};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Input channel
    logic                     i_in_valid      = 1'b0;
    logic                     o_in_stall;
    logic signed [POS_W-1:0]  i_position_word = '0;
    logic signed [SPD_W-1:0]  i_speed_word    = '0;
    logic signed [CUR_W-1:0]  i_current_word  = '0;
    logic        [TEMP_W-1:0] i_temp_byte     = '0;

    // Output channel
    logic                     o_out_valid;
    logic                     i_out_stall     = 1'b0;
    logic signed [POS_W-1:0]  o_rotor_pos;
    logic signed [SPD_W-1:0]  o_rotor_speed;
    logic signed [CUR_W-1:0]  o_torque_cur;
    logic        [TEMP_W-1:0] o_temperature;
    logic signed [SPD_W-1:0]  o_shaft_speed;
    logic signed [TOT_W-1:0]  o_accum_count;
    logic signed [ANG_W-1:0]  o_shaft_angle;

    // Configuration port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Traffic shaping knobs, set per phase by the stimulus.
    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_request = 0;
    int hold_left    = 0;

    // Encoder position of the well-formed rotation walk.
    int walk_pos = 0;

    feedback_scoreboard sb = new();

    motor_feedback_multiturn_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_position_word (i_position_word),
        .i_speed_word    (i_speed_word),
        .i_current_word  (i_current_word),
        .i_temp_byte     (i_temp_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_rotor_pos     (o_rotor_pos),
        .o_rotor_speed   (o_rotor_speed),
        .o_torque_cur    (o_torque_cur),
        .o_temperature   (o_temperature),
        .o_shaft_speed   (o_shaft_speed),
        .o_accum_count   (o_accum_count),
        .o_shaft_angle   (o_shaft_angle),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: stall at the phase's rate, or hold off for a whole stretch
    // when the stimulus asks for one, to back the block up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Check every output transfer against the oldest queued frame.
    always @(posedge i_clk) begin : result_monitor
        t_decoded_frame seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.rotor_pos   = o_rotor_pos;
            seen.rotor_speed = o_rotor_speed;
            seen.torque_cur  = o_torque_cur;
            seen.temperature = o_temperature;
            seen.shaft_speed = o_shaft_speed;
            seen.accum_count = o_accum_count;
            seen.shaft_angle = o_shaft_angle;
            sb.check_result(seen);
        end
    end

    // Offer one frame, idling first at the phase's rate; hold the payload
    // until the transfer and note it for prediction at that edge.
    task automatic send_frame(input logic [POS_W-1:0] pos, input logic [SPD_W-1:0] spd,
                              input logic [CUR_W-1:0] cur, input logic [TEMP_W-1:0] temp);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_position_word <= pos;
        i_speed_word    <= spd;
        i_current_word  <= cur;
        i_temp_byte     <= temp;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_frame(pos, spd, cur, temp);
    endtask

    // Drop valid and wait until every queued frame has come out.
    task automatic settle_results();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the write at the
    // edge where pready is seen high.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_GEAR_RATIO)
            sb.set_gear(data[GEAR_W-1:0]);
    endtask

    // Mostly a plausible rotation (small steps, half-turn ties, wraps),
    // with some zero positions and some full-range noise.
    function automatic logic [POS_W-1:0] next_position();
        int pick;
        int step;
        pick = $urandom_range(99);
        if (pick < 8)
            return POS_W'($urandom);
        if (pick < 12)
            return '0;
        if (pick < 16)
            step = pick[0] ? ENC_COUNTS / 2 : -ENC_COUNTS / 2;
        else if (pick < 60)
            step = int'($urandom_range(400)) - 200;
        else
            step = int'($urandom_range(ENC_COUNTS - 1)) - ENC_COUNTS / 2;
        walk_pos = ((walk_pos + step) % ENC_COUNTS + ENC_COUNTS) % ENC_COUNTS;
        return POS_W'(walk_pos);
    endfunction

    function automatic logic [SPD_W-1:0] next_speed();
        if ($urandom_range(3) == 0)
            return SPD_W'(int'($urandom_range(600)) - 300);
        return SPD_W'($urandom);
    endfunction

    // Idle the block, set the ratio (junk in the unused upper bits), then
    // stream frames under the given idling and stalling. Optionally hold off the
    // receiver at the start and drain halfway through.
    task automatic run_phase(input logic [GEAR_W-1:0] gear, input int idle, input int stall,
                             input int frames, input int hold, input bit pause_mid);
        settle_results();
        apb_write(GEAR_ADDR, {24'($urandom), gear});
        idle_pct     = idle;
        stall_pct    = stall;
        hold_request = hold;
        for (int k = 0; k < frames; k++) begin
            if (pause_mid && k == frames / 2)
                settle_results();
            send_frame(next_position(), next_speed(), SPD_W'($urandom), TEMP_W'($urandom));
        end
    endtask

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at the reset ratio of 1.
        // Zero first position: previous position stays at zero.
        send_frame(16'sd0, 16'h8000, 16'h7fff, 8'd0);
        send_frame(16'sd100, 16'h7fff, 16'h8000, 8'd255);
        // Zero in the middle: the next frame must not adopt it as previous.
        send_frame(16'sd0, -16'sd1, 16'sd0, 8'd1);
        send_frame(16'sd200, 16'sd1, -16'sd1, 8'd128);
        // Backward across the turn boundary, then forward across it.
        send_frame(16'sd8191, -16'sd7, 16'sd7, 8'd127);
        send_frame(16'sd5, 16'sd7, -16'sd7, 8'd64);
        // Exactly half a turn: the two candidate deltas tie.
        send_frame(16'sd4101, 16'sd300, -16'sd300, 8'd2);
        // Full-range encoder words and alternating bit patterns.
        send_frame(16'h8000, 16'h5555, 16'haaaa, 8'h55);
        send_frame(16'h7fff, 16'haaaa, 16'h5555, 8'haa);
        send_frame(16'hffff, -16'sd2, 16'sd2, 8'hfe);
        send_frame(16'h5555, 16'sd0, 16'h7fff, 8'h0f);
        send_frame(16'haaaa, 16'sd3, 16'h8000, 8'hf0);

        // A write to an unmapped index must leave the ratio alone.
        settle_results();
        apb_write(UNUSED_ADDR, 32'd9);
        send_frame(16'sd300, -16'sd9, 16'sd1, 8'd10);
        send_frame(16'sd400, 16'sd9, 16'sd1, 8'd11);

        // Ratio of zero acts as one.
        settle_results();
        apb_write(GEAR_ADDR, {24'($urandom), 8'd0});
        send_frame(16'sd8000, 16'h8000, 16'sd0, 8'd20);
        send_frame(16'sd100, 16'h7fff, 16'sd0, 8'd21);
        send_frame(16'sd50, -16'sd5, 16'sd0, 8'd22);

        // Largest ratio: truncation toward zero at the divisor's edges.
        settle_results();
        apb_write(GEAR_ADDR, {24'($urandom), 8'd255});
        send_frame(16'sd8000, 16'h8000, 16'sd0, 8'd30);
        send_frame(16'sd100, 16'h7fff, 16'sd0, 8'd31);
        send_frame(16'sd4196, -16'sd254, 16'sd0, 8'd32);
        send_frame(16'sd8191, 16'sd254, 16'sd0, 8'd33);
        send_frame(16'sd0, -16'sd255, 16'sd0, 8'd34);

        // Random phases: ratio, sender idle %, receiver stall %, frames,
        // receiver hold-off cycles, drain halfway.
        run_phase(8'd1, 0, 0, 60, 0, 1'b0);
        run_phase(8'd255, 60, 0, 60, 0, 1'b0);
        run_phase(8'd0, 0, 60, 50, 0, 1'b0);
        run_phase(8'd7, 15, 15, 60, 0, 1'b1);
        run_phase(GEAR_W'($urandom_range(2, 254)), 0, 0, 40, 400, 1'b0);
        run_phase(8'd128, 60, 60, 60, 0, 1'b0);
        run_phase(8'd1, 15, 15, 70, 300, 1'b1);

        // Drain, then watch a little longer for stray results.
        settle_results();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
